// File: rtl/i2rd_pkg.sv
// Shared constants and types for the integer to radix digits block.
// Used by every module under rtl; depends on nothing.
package i2rd_pkg;

  localparam int VALUE_W     = 32;
  localparam int SYMBOL_W    = 8;
  localparam int MAX_BASE    = 16;
  localparam int DIGIT_W     = 4;
  localparam int RADIX_W     = 5;
  localparam int STACK_DEPTH = 32;
  localparam int COUNT_W     = 6;
  localparam int STEP_W      = $clog2(VALUE_W);
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_BASE_LENGTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  localparam logic [SYMBOL_W-1:0] SIGN_MINUS = 8'h2D;
  localparam logic [SYMBOL_W-1:0] SIGN_PLUS  = 8'h2B;
  localparam logic [SYMBOL_W-1:0] SYMBOL_NUL = 8'h00;

  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic               valid;
  } cfg_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_status_t;

endpackage

// File: rtl/i2rd_cfg.sv
// Configuration registers, base check and symbol lookup.
// Depends on i2rd_pkg.
module i2rd_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [i2rd_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  logic [i2rd_pkg::CFG_DATA_W-1:0]     wr_data,
  input  logic [i2rd_pkg::DIGIT_W-1:0]        sym_index,
  output logic [i2rd_pkg::SYMBOL_W-1:0]       symbol,
  output i2rd_pkg::cfg_t                      cfg
);

  logic [i2rd_pkg::RADIX_W-1:0]    base_length;
  logic [i2rd_pkg::CFG_DATA_W-1:0] symbols_low;
  logic [i2rd_pkg::CFG_DATA_W-1:0] symbols_high;
  logic [i2rd_pkg::SYMBOL_W-1:0]   symbols [i2rd_pkg::MAX_BASE];
  logic                            ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_length  <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
    end else if (wr_en) begin
      case (wr_index)
        i2rd_pkg::REG_BASE_LENGTH:  base_length  <= wr_data[i2rd_pkg::RADIX_W-1:0];
        i2rd_pkg::REG_SYMBOLS_LOW:  symbols_low  <= wr_data;
        i2rd_pkg::REG_SYMBOLS_HIGH: symbols_high <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      symbols[i]     = symbols_low[8*i +: 8];
      symbols[i + 8] = symbols_high[8*i +: 8];
    end
  end

  always_comb begin
    ok = (base_length >= 5'd2) && (base_length <= 5'(i2rd_pkg::MAX_BASE));
    for (int i = 0; i < i2rd_pkg::MAX_BASE; i++) begin
      if (5'(i) < base_length) begin
        if (symbols[i] == i2rd_pkg::SYMBOL_NUL || symbols[i] == i2rd_pkg::SIGN_PLUS ||
            symbols[i] == i2rd_pkg::SIGN_MINUS)
          ok = 1'b0;
        for (int j = i + 1; j < i2rd_pkg::MAX_BASE; j++) begin
          if (5'(j) < base_length && symbols[j] == symbols[i]) ok = 1'b0;
        end
      end
    end
  end

  assign cfg.radix = base_length;
  assign cfg.valid = ok;
  assign symbol    = symbols[sym_index];

endmodule

// File: rtl/i2rd_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on i2rd_pkg.
module i2rd_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [i2rd_pkg::VALUE_W-1:0]    operand,
  input  logic [i2rd_pkg::RADIX_W-1:0]    radix,
  output i2rd_pkg::div_status_t           status
);

  logic [i2rd_pkg::VALUE_W-1:0] q;
  logic [i2rd_pkg::DIGIT_W-1:0] rem;
  logic [i2rd_pkg::STEP_W-1:0]  step;
  logic                         busy;
  logic                         done;
  logic [i2rd_pkg::RADIX_W-1:0] trial;
  logic                         ge;

  assign trial = {rem, q[i2rd_pkg::VALUE_W-1]};
  assign ge    = trial >= radix;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == i2rd_pkg::STEP_W'(i2rd_pkg::VALUE_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= operand;
      rem <= '0;
    end else if (busy) begin
      q   <= {q[i2rd_pkg::VALUE_W-2:0], ge};
      rem <= ge ? i2rd_pkg::DIGIT_W'(trial - radix) : i2rd_pkg::DIGIT_W'(trial);
    end
  end

  assign status.done      = done;
  assign status.quotient  = q;
  assign status.remainder = rem;

endmodule

// File: rtl/i2rd_stack.sv
// Digit stack as a shift register: push at the top, pop from the top.
// Depends on i2rd_pkg.
module i2rd_stack (
  input  logic                          clk,
  input  logic                          push,
  input  logic                          pop,
  input  logic [i2rd_pkg::DIGIT_W-1:0]  din,
  output logic [i2rd_pkg::DIGIT_W-1:0]  top
);

  logic [i2rd_pkg::DIGIT_W-1:0] slots [i2rd_pkg::STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[0] <= din;
      for (int i = 1; i < i2rd_pkg::STACK_DEPTH; i++) slots[i] <= slots[i-1];
    end else if (pop) begin
      for (int i = 0; i < i2rd_pkg::STACK_DEPTH - 1; i++) slots[i] <= slots[i+1];
    end
  end

  assign top = slots[0];

endmodule

// File: rtl/integer_to_radix_digits.sv
// Top level: signed integer to text in a configured radix, sign and
// control sequencer. Depends on i2rd_pkg, i2rd_cfg, i2rd_div, i2rd_stack.
//
// Usage: write base_length (index 0), symbols_low (1), symbols_high (2)
// through wr_en/wr_index/wr_data while the block is idle. Send a signed
// 32-bit value on the s_ channel; the text comes out on the m_ channel one
// character per transfer, most significant digit first, '-' ahead of a
// negative value, m_tlast on the final character. With an invalid base the
// value is taken and dropped, with no output.
// Conversion: each digit is one pass of the bit-serial divider (a shift step
// per quotient bit, then the digit is pushed on the stack); the characters
// then leave one character per cycle while the receiver keeps m_tready
// high.
// The block takes one item at a time: s_tready is high only between items.
// A finished character waits in the output register while m_tready is low;
// the sequencer holds the next character until it is taken.
// Reset clears the registers to zero (invalid base), the output valid and
// the sequencer; no clearing pass is needed.
module integer_to_radix_digits (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [31:0]                         s_tdata,   // [31:0] value
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [7:0]                          m_tdata,   // [7:0] character
  output logic                                m_tlast,
  input  logic                                wr_en,
  input  logic [i2rd_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  logic [i2rd_pkg::CFG_DATA_W-1:0]     wr_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_SIGN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                          state, state_next;
  logic [i2rd_pkg::COUNT_W-1:0]    digit_count, digit_count_next;
  logic                            negative, negative_next;
  logic [i2rd_pkg::VALUE_W-1:0]    operand;
  logic                            div_start;
  logic                            push, pop, load_out, out_free;
  logic [i2rd_pkg::SYMBOL_W-1:0]   char_next;
  logic                            last_next;
  logic [i2rd_pkg::DIGIT_W-1:0]    top_digit;
  logic [i2rd_pkg::SYMBOL_W-1:0]   symbol;
  i2rd_pkg::cfg_t                  cfg;
  i2rd_pkg::div_status_t           div_st;

  i2rd_cfg u_cfg (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .sym_index(top_digit), .symbol(symbol), .cfg(cfg)
  );

  i2rd_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .operand(operand), .radix(cfg.radix),
    .status(div_st)
  );

  i2rd_stack u_stack (
    .clk(clk), .push(push), .pop(pop), .din(div_st.remainder), .top(top_digit)
  );

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next       = state;
    digit_count_next = digit_count;
    negative_next    = negative;
    operand          = s_tdata[31] ? (32'd0 - s_tdata) : s_tdata;
    div_start        = 1'b0;
    push             = 1'b0;
    pop              = 1'b0;
    load_out         = 1'b0;
    char_next        = symbol;
    last_next        = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_tvalid && cfg.valid) begin
          div_start        = 1'b1;
          digit_count_next = '0;
          negative_next    = s_tdata[31];
          state_next       = S_DIV;
        end
      end
      S_DIV: begin
        operand = div_st.quotient;
        if (div_st.done) begin
          push             = 1'b1;
          digit_count_next = digit_count + 1'b1;
          if ((|div_st.quotient) &&
              (digit_count_next < i2rd_pkg::COUNT_W'(i2rd_pkg::STACK_DEPTH)))
            div_start = 1'b1;
          else
            state_next = negative ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          load_out   = 1'b1;
          char_next  = i2rd_pkg::SIGN_MINUS;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load_out         = 1'b1;
          pop              = 1'b1;
          last_next        = (digit_count == i2rd_pkg::COUNT_W'(1));
          digit_count_next = digit_count - 1'b1;
          if (digit_count == i2rd_pkg::COUNT_W'(1)) state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      digit_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      digit_count <= digit_count_next;
      if (load_out)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    negative <= negative_next;
    if (load_out) begin
      m_tdata <= char_next;
      m_tlast <= last_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= i2rd_pkg::COUNT_W'(i2rd_pkg::STACK_DEPTH))
    else $error("digit count beyond stack depth");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (digit_count != '0))
    else $error("emit with empty digit stack");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == S_DIV))
    else $error("divider result outside division phase");

  a_invalid_drop: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !cfg.valid) |=> (state == S_IDLE) && !load_out)
    else $error("item taken with invalid base");
`endif

endmodule
